>>> rtl/core/utf8_stream_validator_macros.svh
// Assertion macros used by the UTF-8 stream validator RTL.
`ifndef UTF8_STREAM_VALIDATOR_MACROS_SVH
`define UTF8_STREAM_VALIDATOR_MACROS_SVH

`ifndef SYNTHESIS

`define UTF8V_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("utf8 validator: implication check failed");

`define UTF8V_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("utf8 validator: next-cycle check failed");

`else

`define UTF8V_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define UTF8V_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/utf8v_pkg.sv
// Types, constants and range checks for the UTF-8 stream validator.
package utf8v_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned PENDING_W = 2;
    localparam int unsigned CLASS_W   = 3;

    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [PENDING_W-1:0] t_pending;
    typedef logic [CLASS_W-1:0]   t_class;

    localparam t_class CLASS_GENERIC = 3'd0;
    localparam t_class CLASS_AFTER_E0 = 3'd1;
    localparam t_class CLASS_AFTER_ED = 3'd2;
    localparam t_class CLASS_AFTER_F0 = 3'd3;
    localparam t_class CLASS_AFTER_F4 = 3'd4;

    localparam t_pending PEND_NONE  = 2'd0;
    localparam t_pending PEND_ONE   = 2'd1;
    localparam t_pending PEND_TWO   = 2'd2;
    localparam t_pending PEND_THREE = 2'd3;

    typedef struct packed {
        t_pending pending_count;
        t_class   second_class;
        logic     error_seen;
    } t_state;

    localparam t_state STATE_CLEAR = '{
        pending_count: PEND_NONE,
        second_class:  CLASS_GENERIC,
        error_seen:    1'b0
    };

    // Checks a byte against the range allowed by the current second-byte class.
    function automatic logic continuation_ok(input t_byte b, input t_class cls);
        logic ok;
        case (cls)
            CLASS_AFTER_E0: ok = b inside {[8'hA0:8'hBF]};
            CLASS_AFTER_ED: ok = b inside {[8'h80:8'h9F]};
            CLASS_AFTER_F0: ok = b inside {[8'h90:8'hBF]};
            CLASS_AFTER_F4: ok = b inside {[8'h80:8'h8F]};
            default:        ok = b inside {[8'h80:8'hBF]};
        endcase
        return ok;
    endfunction

endpackage

>>> rtl/core/utf8_stream_validator.sv
// UTF-8 stream validator: RFC 3629 check of a byte string that also rejects NUL bytes, one byte a transfer.
// A terminating transfer passes the input register, then its verdict is held in the output register.
// Throughput: one byte per cycle unless stalled; the input register drains into the state when not stalled.
// The input side stalls only while a terminating byte waits and a verdict in the output register is stalled.
// Reset (synchronous, active low) empties both registers and clears the sequence state.
`include "utf8_stream_validator_macros.svh"

module utf8_stream_validator (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  utf8v_pkg::t_byte i_byte_value,
    input  logic             i_last_byte,
    input  logic             i_empty_string,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_string_valid
);

    logic             r_in_valid;
    utf8v_pkg::t_byte r_byte;
    logic             r_last;
    logic             r_empty;

    utf8v_pkg::t_state r_state;
    utf8v_pkg::t_state n_state;
    utf8v_pkg::t_state byte_state;

    logic r_out_valid;
    logic r_verdict;

    logic in_term;
    logic advance;
    logic out_take;

    assign in_term  = r_empty || r_last;
    assign out_take = r_out_valid && !i_out_stall;
    assign advance  = r_in_valid && (!in_term || !r_out_valid || !i_out_stall);

    assign o_in_stall     = r_in_valid && !advance;
    assign o_out_valid    = r_out_valid;
    assign o_string_valid = r_verdict;

    // State after the registered byte is taken, ignoring string termination.
    always_comb begin
        byte_state = r_state;
        if (!r_empty && !r_state.error_seen) begin
            if (r_state.pending_count != utf8v_pkg::PEND_NONE) begin
                if (utf8v_pkg::continuation_ok(r_byte, r_state.second_class)) begin
                    byte_state.pending_count = r_state.pending_count - 2'd1;
                    byte_state.second_class  = utf8v_pkg::CLASS_GENERIC;
                end else begin
                    byte_state.error_seen = 1'b1;
                end
            end else begin
                if (r_byte == 8'h00) begin
                    byte_state.error_seen = 1'b1;
                end else if (r_byte inside {[8'h01:8'h7F]}) begin
                    byte_state = r_state;
                end else if (r_byte inside {[8'hC2:8'hDF]}) begin
                    byte_state.pending_count = utf8v_pkg::PEND_ONE;
                    byte_state.second_class  = utf8v_pkg::CLASS_GENERIC;
                end else if (r_byte inside {[8'hE0:8'hEF]}) begin
                    byte_state.pending_count = utf8v_pkg::PEND_TWO;
                    if (r_byte == 8'hE0) begin
                        byte_state.second_class = utf8v_pkg::CLASS_AFTER_E0;
                    end else if (r_byte == 8'hED) begin
                        byte_state.second_class = utf8v_pkg::CLASS_AFTER_ED;
                    end else begin
                        byte_state.second_class = utf8v_pkg::CLASS_GENERIC;
                    end
                end else if (r_byte inside {[8'hF0:8'hF4]}) begin
                    byte_state.pending_count = utf8v_pkg::PEND_THREE;
                    if (r_byte == 8'hF0) begin
                        byte_state.second_class = utf8v_pkg::CLASS_AFTER_F0;
                    end else if (r_byte == 8'hF4) begin
                        byte_state.second_class = utf8v_pkg::CLASS_AFTER_F4;
                    end else begin
                        byte_state.second_class = utf8v_pkg::CLASS_GENERIC;
                    end
                end else begin
                    byte_state.error_seen = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        if (advance) begin
            n_state = in_term ? utf8v_pkg::STATE_CLEAR : byte_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= utf8v_pkg::STATE_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            r_state <= n_state;
            if (advance && in_term) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_byte  <= i_byte_value;
            r_last  <= i_last_byte;
            r_empty <= i_empty_string;
        end
        if (advance && in_term) begin
            r_verdict <= !byte_state.error_seen
                         && (byte_state.pending_count == utf8v_pkg::PEND_NONE);
        end
    end

    `UTF8V_ASSERT_IMPLIES(a_stall_needs_full_output, i_clk, i_rst_n, o_in_stall, r_in_valid && r_out_valid)
    `UTF8V_ASSERT_IMPLIES(a_class_needs_pending, i_clk, i_rst_n, r_state.second_class != utf8v_pkg::CLASS_GENERIC, r_state.pending_count != utf8v_pkg::PEND_NONE)
    `UTF8V_ASSERT_NEXT(a_term_loads_verdict, i_clk, i_rst_n, advance && in_term, r_out_valid)
    `UTF8V_ASSERT_NEXT(a_term_clears_state, i_clk, i_rst_n, advance && in_term, r_state == utf8v_pkg::STATE_CLEAR)

endmodule
